// ===== src/per_event_duration_statistics_macros.svh =====
// assertion macros shared by the rtl files
`ifndef PER_EVENT_DURATION_STATISTICS_MACROS_SVH
`define PER_EVENT_DURATION_STATISTICS_MACROS_SVH

`ifndef ASSERT_OFF
// checked property on clk, masked during reset
`define PEDST_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pedst assertion failed");
// same with a custom message
`define PEDST_ASSERT_MSG(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define PEDST_ASSERT(name, prop)
`define PEDST_ASSERT_MSG(name, prop, msg)
`endif

`endif

// ===== src/pedst_pkg.sv =====
`default_nettype none

package pedst_pkg;

    localparam int ID_W        = 16;
    localparam int TIME_W      = 48;
    localparam int COUNT_W     = 32;
    localparam int SUM_W       = 64;
    localparam int MEAN_W      = 56;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 240;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_UPDATED = 3'd0,
        ST_NEW     = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISS    = 3'd3,
        ST_HIT     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_APPLY,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    // one table record
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  min;
        logic [TIME_W-1:0]  max;
        logic [SUM_W-1:0]   sum;
        logic [TIME_W-1:0]  last;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic in_ready;
        logic scan_read;
        logic scan_check;
        logic apply;
        logic div_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic    in_accept;
        action_t in_act;
        logic    scan_last;
        logic    use_div;
        logic    div_busy;
        logic    out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/per_event_duration_statistics.sv =====
// Per-event duration monitor. A start transfer latches time_now; a stop transfer
// measures time_now minus that latch (mod 2^48), clears the latch, and records the
// duration in the table entry of event_id (count, min, max, saturating sum, last),
// creating the entry if needed; a query transfer reports an entry unchanged. Stop
// and query each give one result transfer with the mean as sum*2^MEAN_FRACTION_BITS
// /count; start gives none, action code 3 is ignored. A stop or query that finds or
// creates an entry scans the table, which is one RAM read one entry at a time (a
// read state, then a compare state) for the id match and the first free entry,
// then a bit-serial divider produces the mean one quotient bit per cycle. A query
// miss or a stop dropped at a full table skips the divider. The controller returns
// to idle before the next input transfer, and a result still held by the receiver
// delays loading the next one. A finished result waits in an output register while
// the next input is taken.
`default_nettype none

module per_event_duration_statistics
    import pedst_pkg::*;
#(
    parameter int TABLE_ENTRIES      = 16,
    parameter int MEAN_FRACTION_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // action[1:0], event_id[17:2], time_now[65:18], zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status[2:0], call_count[34:3], min_duration[82:35], max_duration[130:83],
    // mean_duration[186:131], last_duration[234:187], zero fill
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    cmd_t cmd;
    sts_t sts;

    pedst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pedst_dp #(
        .TABLE_ENTRIES      (TABLE_ENTRIES),
        .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule

`default_nettype wire

// ===== src/pedst_ram.sv =====
`default_nettype none

module pedst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/pedst_div.sv =====
`default_nettype none

module pedst_div #(
    parameter int DVD_W = 72,
    parameter int DVS_W = 32,
    parameter int Q_W   = 56
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  busy,
    output logic      [Q_W-1:0]   quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             ovf_reg, ovf_next;
    logic             zero_reg, zero_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    // one restoring step per cycle
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = !diff[DVS_W];
    end

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            zero_next = (divisor == '0);
            cnt_next  = CW'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next  = dvd_reg << 1;
            rem_next  = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            q_next    = {q_reg[Q_W-2:0], ge};
            ovf_next  = ovf_reg | q_reg[Q_W-1];
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        zero_reg <= zero_next;
    end

    // zero divisor gives zero, overflow saturates
    assign busy     = busy_reg;
    assign quotient = zero_reg ? '0 : (ovf_reg ? '1 : q_reg);

endmodule

`default_nettype wire

// ===== src/pedst_ctrl.sv =====
`default_nettype none
`include "per_event_duration_statistics_macros.svh"

module pedst_ctrl
    import pedst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sts.in_accept &&
                    (sts.in_act == ACT_STOP || sts.in_act == ACT_QUERY))
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:  state_next = S_SCAN_CMP;
            S_SCAN_CMP: state_next = sts.scan_last ? S_APPLY : S_SCAN_RD;
            S_APPLY:    state_next = sts.use_div ? S_DIV_GO : S_DONE;
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:     cmd.in_ready   = 1'b1;
            S_SCAN_RD:  cmd.scan_read  = 1'b1;
            S_SCAN_CMP: cmd.scan_check = 1'b1;
            S_APPLY:    cmd.apply      = 1'b1;
            S_DIV_GO:   cmd.div_load   = 1'b1;
            S_DIV_WAIT: cmd = '0;
            S_DONE:     cmd.out_load   = sts.out_free;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `PEDST_ASSERT(a_load_free, cmd.out_load |-> sts.out_free)
    `PEDST_ASSERT(a_check_after_read, cmd.scan_check |-> $past(cmd.scan_read))
    `PEDST_ASSERT_MSG(a_div_after_apply, cmd.div_load |-> $past(cmd.apply), "divide out of order")

endmodule

`default_nettype wire

// ===== src/pedst_dp.sv =====
`default_nettype none
`include "per_event_duration_statistics_macros.svh"

module pedst_dp
    import pedst_pkg::*;
#(
    parameter int TABLE_ENTRIES      = 16,
    parameter int MEAN_FRACTION_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    output sts_t                        sts,
    input  wire logic                   s_axis_tvalid,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int DVD_W = SUM_W + MEAN_FRACTION_BITS;

    // input fields
    action_t          in_act;
    logic [ID_W-1:0]  in_id;
    logic [TIME_W-1:0] in_now;
    logic             accept;

    logic [TIME_W-1:0] start_reg;
    action_t           act_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] dur_reg;
    logic [IW-1:0]     idx_reg;
    logic              hit_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic              free_reg;
    logic [IW-1:0]     free_idx_reg;
    entry_t            rec_reg;
    status_t           res_status_reg;
    logic              res_div_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic              out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    entry_t            ram_rdata;
    entry_t            ram_wdata;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    entry_t            upd;
    logic [SUM_W:0]    sum_add;
    logic              div_busy;
    logic [MEAN_W-1:0] div_q;
    logic [MEAN_W-1:0] mean_val;

    assign in_act = action_t'(s_axis_tdata[1:0]);
    assign in_id  = s_axis_tdata[17:2];
    assign in_now = s_axis_tdata[65:18];
    assign accept = cmd.in_ready && s_axis_tvalid;

    // start time latch and item capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (accept)
        begin
            if (in_act == ACT_START)
            begin
                start_reg <= in_now;
            end
            else if (in_act == ACT_STOP)
            begin
                start_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= in_act;
            id_reg  <= in_id;
            dur_reg <= in_now - start_reg;
        end
    end

    // table scan: first match and first free entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (accept)
        begin
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.scan_check)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (valid_reg[idx_reg] && ram_rdata.id == id_reg && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (!valid_reg[idx_reg] && !free_reg)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_check)
        begin
            if (valid_reg[idx_reg] && ram_rdata.id == id_reg && !hit_reg)
            begin
                hit_idx_reg <= idx_reg;
            end
            if (!valid_reg[idx_reg] && !free_reg)
            begin
                free_idx_reg <= idx_reg;
            end
        end
    end

    assign sts.in_accept = accept;
    assign sts.in_act    = in_act;
    assign sts.scan_last = (idx_reg == IW'(TABLE_ENTRIES - 1));
    assign sts.use_div   = hit_reg || (act_reg == ACT_STOP && free_reg);
    assign sts.div_busy  = div_busy;
    assign sts.out_free  = !out_valid_reg || m_axis_tready;

    // record update for a stop that hits
    always_comb
    begin
        sum_add   = {1'b0, rec_reg.sum} + (SUM_W + 1)'(dur_reg);
        upd       = rec_reg;
        upd.count = (rec_reg.count == '1) ? rec_reg.count : rec_reg.count + 1'b1;
        upd.sum   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        upd.min   = (dur_reg < rec_reg.min) ? dur_reg : rec_reg.min;
        upd.max   = (dur_reg > rec_reg.max) ? dur_reg : rec_reg.max;
        upd.last  = dur_reg;
    end

    // table write
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = hit_idx_reg;
        ram_wdata = upd;
        if (cmd.apply && act_reg == ACT_STOP)
        begin
            if (hit_reg)
            begin
                ram_we = 1'b1;
            end
            else if (free_reg)
            begin
                ram_we          = 1'b1;
                ram_waddr       = free_idx_reg;
                ram_wdata.id    = id_reg;
                ram_wdata.count = COUNT_W'(1);
                ram_wdata.min   = dur_reg;
                ram_wdata.max   = dur_reg;
                ram_wdata.sum   = SUM_W'(dur_reg);
                ram_wdata.last  = dur_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.apply && act_reg == ACT_STOP && !hit_reg && free_reg)
        begin
            valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    // working record and result status
    always_ff @(posedge clk)
    begin
        if (cmd.scan_check && valid_reg[idx_reg] && ram_rdata.id == id_reg && !hit_reg)
        begin
            rec_reg <= ram_rdata;
        end
        else if (cmd.apply)
        begin
            res_div_reg <= sts.use_div;
            if (act_reg == ACT_STOP)
            begin
                if (hit_reg)
                begin
                    rec_reg        <= upd;
                    res_status_reg <= ST_UPDATED;
                end
                else if (free_reg)
                begin
                    rec_reg        <= ram_wdata;
                    res_status_reg <= ST_NEW;
                end
                else
                begin
                    // only the duration survives, in the lowest field
                    rec_reg        <= entry_t'(ENTRY_W'(dur_reg));
                    res_status_reg <= ST_FULL;
                end
            end
            else if (hit_reg)
            begin
                res_status_reg <= ST_HIT;
            end
            else
            begin
                rec_reg        <= '0;
                res_status_reg <= ST_MISS;
            end
        end
    end

    pedst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    pedst_div #(
        .DVD_W (DVD_W),
        .DVS_W (COUNT_W),
        .Q_W   (MEAN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_load),
        .dividend (DVD_W'(rec_reg.sum) << MEAN_FRACTION_BITS),
        .divisor  (rec_reg.count),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign mean_val = res_div_reg ? div_q : '0;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {5'b0, rec_reg.last, mean_val, rec_reg.max, rec_reg.min,
                             rec_reg.count, res_status_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `PEDST_ASSERT(a_valid_grow, $countones(valid_reg) >= $past($countones(valid_reg)))
    `PEDST_ASSERT(a_write_in_apply, ram_we |-> cmd.apply)

endmodule

`default_nettype wire

// ===== dv/tb_per_event_duration_statistics.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_per_event_duration_statistics
    import pedst_pkg::*;
();

    localparam int N_ENTRIES = 16;
    localparam int FRAC_BITS = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] call_count;
        logic [47:0] min_duration;
        logic [47:0] max_duration;
        logic [55:0] mean_duration;
        logic [47:0] last_duration;
    } stats_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    per_event_duration_statistics dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow copy of the event table
    logic [47:0] shadow_start;
    logic        shadow_valid [N_ENTRIES];
    logic [15:0] shadow_id    [N_ENTRIES];
    logic [31:0] shadow_count [N_ENTRIES];
    logic [47:0] shadow_min   [N_ENTRIES];
    logic [47:0] shadow_max   [N_ENTRIES];
    logic [63:0] shadow_sum   [N_ENTRIES];
    logic [47:0] shadow_last  [N_ENTRIES];

    stats_t expected_stats [$];
    int     mismatches;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     idle_cycles;
    bit     timed_out;

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [55:0] fixed_mean(logic [63:0] sum, logic [31:0] count);
        logic [63:0] quo;
        logic [63:0] rem;
        if (count == 0)
            return '0;
        quo = sum / count;
        rem = sum % count;
        if (quo >= (64'd1 << (56 - FRAC_BITS)))
            return '1;
        return 56'((quo << FRAC_BITS) + ((rem << FRAC_BITS) / count));
    endfunction

    function automatic stats_t entry_stats(int e, logic [2:0] status);
        stats_t r;
        r.status        = status;
        r.call_count    = shadow_count[e];
        r.min_duration  = shadow_min[e];
        r.max_duration  = shadow_max[e];
        r.mean_duration = fixed_mean(shadow_sum[e], shadow_count[e]);
        r.last_duration = shadow_last[e];
        return r;
    endfunction

    function automatic int lookup_id(logic [15:0] id);
        for (int i = 0; i < N_ENTRIES; i++)
            if (shadow_valid[i] && shadow_id[i] == id)
                return i;
        return -1;
    endfunction

    // update the shadow table for one accepted transfer, queue any result
    task automatic record_event(logic [1:0] act, logic [15:0] id, logic [47:0] now);
        logic [47:0] dur;
        int          e;
        stats_t      r;
        if (act == ACT_START)
        begin
            shadow_start = now;
        end
        else if (act == ACT_QUERY)
        begin
            e = lookup_id(id);
            if (e < 0)
            begin
                r = '0;
                r.status = ST_MISS;
            end
            else
                r = entry_stats(e, ST_HIT);
            expected_stats.push_back(r);
        end
        else if (act == ACT_STOP)
        begin
            dur = now - shadow_start;
            shadow_start = '0;
            e = lookup_id(id);
            if (e >= 0)
            begin
                if (shadow_count[e] != 32'hFFFF_FFFF)
                    shadow_count[e]++;
                shadow_sum[e] = (shadow_sum[e] > ~64'(dur)) ? '1 : shadow_sum[e] + dur;
                if (dur < shadow_min[e])
                    shadow_min[e] = dur;
                if (dur > shadow_max[e])
                    shadow_max[e] = dur;
                shadow_last[e] = dur;
                expected_stats.push_back(entry_stats(e, ST_UPDATED));
            end
            else
            begin
                for (int i = 0; i < N_ENTRIES; i++)
                    if (!shadow_valid[i] && e < 0)
                        e = i;
                if (e < 0)
                begin
                    r = '0;
                    r.status = ST_FULL;
                    r.last_duration = dur;
                    expected_stats.push_back(r);
                end
                else
                begin
                    shadow_valid[e] = 1'b1;
                    shadow_id[e]    = id;
                    shadow_count[e] = 1;
                    shadow_sum[e]   = dur;
                    shadow_min[e]   = dur;
                    shadow_max[e]   = dur;
                    shadow_last[e]  = dur;
                    expected_stats.push_back(entry_stats(e, ST_NEW));
                end
            end
        end
    endtask

    // send one transfer, with random idle cycles before it
    task automatic send_event(logic [1:0] act, logic [15:0] id, logic [47:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, now, id, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        record_event(act, id, now);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_stats.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    // receiver backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        stats_t got;
        stats_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status        = m_axis_tdata[2:0];
            got.call_count    = m_axis_tdata[34:3];
            got.min_duration  = m_axis_tdata[82:35];
            got.max_duration  = m_axis_tdata[130:83];
            got.mean_duration = m_axis_tdata[186:131];
            got.last_duration = m_axis_tdata[234:187];
            if (expected_stats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", got);
            end
            else
            begin
                want = expected_stats.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: st %0d/%0d cnt %0d/%0d ",
                                 want.status, got.status,
                                 want.call_count, got.call_count,
                                 "min %0d/%0d max %0d/%0d ",
                                 want.min_duration, got.min_duration,
                                 want.max_duration, got.max_duration,
                                 "mean %0d/%0d last %0d/%0d",
                                 want.mean_duration, got.mean_duration,
                                 want.last_duration, got.last_duration);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [47:0] rand_time();
        logic [47:0] t;
        t = 48'({$urandom, $urandom});
        case ($urandom_range(3))
            0: t = '0;
            1: t = TIME_MAX;
            default: ;
        endcase
        return t;
    endfunction

    // directed: extremes, every action, the special cases
    task automatic test_directed();
        send_event(ACT_STOP, 16'h0000, 48'd1000);        // stop without start
        send_event(ACT_QUERY, 16'h0000, '0);
        send_event(ACT_QUERY, 16'hFFFF, TIME_MAX);       // query miss
        send_event(ACT_START, 16'hFFFF, TIME_MAX);
        send_event(ACT_STOP, 16'hFFFF, 48'd5);           // wraps modulo 2^48
        send_event(2'd3, 16'h1234, 48'd77);              // unused code, ignored
        send_event(ACT_START, 16'h0000, 48'd10);
        send_event(ACT_STOP, 16'h0000, 48'd10);          // zero duration
        send_event(ACT_STOP, 16'h0000, TIME_MAX);        // max duration
        send_event(ACT_QUERY, 16'h0000, '0);
        send_event(ACT_QUERY, 16'hFFFF, '0);
        // fill the table then overflow it
        for (int i = 1; i < N_ENTRIES + 1; i++)
            send_event(ACT_STOP, 16'(i * 16'h0F0F), 48'(i * 3));
        send_event(ACT_QUERY, 16'h0F0F, '0);
        send_event(ACT_START, 16'h5555, 48'hAAAA_AAAA_AAAA);
        send_event(ACT_STOP, 16'hAAAA, 48'h5555_5555_5555);
        drain_results();
    endtask

    // long durations and a large mean on one entry
    task automatic test_saturation();
        for (int i = 0; i < 40; i++)
            send_event(ACT_STOP, 16'hFFFF, TIME_MAX - 48'(i));
        send_event(ACT_QUERY, 16'hFFFF, '0);
        drain_results();
    endtask

    task automatic test_random(int n_items);
        logic [1:0]  act;
        logic [15:0] id;
        for (int i = 0; i < n_items && !timed_out; i++)
        begin
            // mostly well-formed start/stop pairs on known ids
            if ($urandom_range(9) < 8)
            begin
                id = shadow_valid[$urandom_range(N_ENTRIES - 1)] ?
                     shadow_id[$urandom_range(N_ENTRIES - 1)] : 16'($urandom);
                if (!shadow_valid[0] && $urandom_range(1))
                    id = 16'($urandom);
                act = ($urandom_range(3) == 0) ? ACT_QUERY : ACT_START;
                send_event(act, id, rand_time());
                if (act == ACT_START)
                    send_event(ACT_STOP, id, ($urandom_range(1) ?
                               shadow_start + 48'($urandom_range(100000)) : rand_time()));
            end
            else
                send_event(2'($urandom), 16'($urandom), rand_time());
        end
        drain_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        send_idle_pct = 19;
        recv_idle_pct = 59;
        shadow_start  = '0;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_id[i]    = '0;
            shadow_count[i] = '0;
            shadow_min[i]   = '0;
            shadow_max[i]   = '0;
            shadow_sum[i]   = '0;
            shadow_last[i]  = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_saturation();
        test_random(360);
        send_idle_pct = 59;
        recv_idle_pct = 19;
        test_random(360);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(360);

        if (mismatches == 0 && expected_stats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
